// ----- rtl/lrpe_pkg.sv -----
// Shared constants, datapath command codes and controller/datapath bundles.
package lrpe_pkg;

    localparam int COUNT_BITS   = 32;
    localparam int DEFAULT_RATE = 48000;
    localparam int MAX_CHANNELS = 8;
    localparam int VALUE_CAP    = 8;
    localparam int DIV_W        = 61;
    localparam int DVS_W        = 29;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [1:0] REG_IN_RATE  = 2'd0;
    localparam logic [1:0] REG_OUT_RATE = 2'd1;
    localparam logic [1:0] REG_FORMAT   = 2'd2;
    localparam logic [1:0] REG_CHANNELS = 2'd3;

    localparam logic [1:0] FMT_U8  = 2'd0;
    localparam logic [1:0] FMT_S16 = 2'd1;
    localparam logic [1:0] FMT_S32 = 2'd2;
    localparam logic [1:0] FMT_F32 = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_MUL_N, OP_DIV_T, OP_SET_T, OP_MUL_I, OP_DIV_P, OP_MIN_PE,
        OP_FIX_T, OP_LOAD_HELD, OP_MUL_K, OP_CUR_X, OP_MUL_A, OP_MUL_B, OP_DIV_I,
        OP_SET_X, OP_CLAMP, OP_MUL_E, OP_DIV_E, OP_SET_CODE, OP_ZERO_CODE, OP_FLT_INIT,
        OP_FLT_SHIFT, OP_DIV_F, OP_FLT_CODE, OP_NEXT_C, OP_NEXT_J, OP_ADV, OP_HELD_SET,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       last;
        logic       held_vld;
        logic       j_done;
        logic       first_held;
        logic       kin_ge;
        logic       kin_le;
        logic [1:0] fmt;
        logic       m_zero;
        logic       sh_low;
        logic       c_last;
    } dp_stat_t;

endpackage

// ----- rtl/lrpe_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module lrpe_div
    import lrpe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [DVS_W-1:0] remainder,
    output logic             done
);

    logic [DIV_W-1:0]         quo_reg;
    logic [DVS_W-1:0]         rem_reg;
    logic [DVS_W-1:0]         dvs_reg;
    logic [$clog2(DIV_W)-1:0] cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [DVS_W:0]           shifted;
    logic [DVS_W+1:0]         diff;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= diff[DVS_W+1] ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], ~diff[DVS_W+1]};
                if (cnt_reg == ($clog2(DIV_W))'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ----- rtl/lrpe_dp.sv -----
// Datapath: configuration, buffer state, shared multiplier, divider and encoder.
module lrpe_dp
    import lrpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [31:0] s_tdata,
    input  logic        s_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_wdata,
    output logic [39:0] m_tdata,
    output logic        m_tlast,
    output logic [0:0]  m_tuser
);

    localparam logic [27:0] FULL_SCALE = 28'd83886080;
    localparam logic [28:0] FS2        = 29'd167772160;
    localparam logic [51:0] FLT_LIMIT  = 52'd703687441776640;
    localparam logic signed [39:0] FS40 = 40'sd83886080;
    localparam logic [10:0] RECIP5     = 11'd1639;

    logic [19:0] in_rate_reg;
    logic [17:0] out_rate_reg;
    logic [1:0]  fmt_reg;
    logic [3:0]  chan_reg;

    logic signed [31:0] prev_reg, cur_reg;
    logic [COUNT_BITS-1:0] idx_reg, oidx_reg, target_reg, k_reg;
    logic signed [39:0] held_reg, x_reg;
    logic        held_vld_reg, last_reg;
    logic [59:0] prod_reg;
    logic [49:0] iout_reg;
    logic [51:0] kin_reg;
    logic [17:0] num_reg;
    logic signed [52:0] acc_reg;
    logic        dneg_reg;
    logic signed [27:0] xc_reg;
    logic [26:0] m_reg;
    logic        fneg_reg;
    logic [51:0] sh_reg;
    logic [5:0]  s_reg;
    logic [31:0] code_reg;
    logic [3:0]  j_reg, nvals_reg;
    logic [2:0]  c_reg;

    logic [39:0] c5_y_reg, c5_q_reg;
    logic [2:0]  c5_r_reg, c5_cnt_reg;
    logic [23:0] c5_low_reg;
    logic        c5_busy_reg, c5_done_reg;

    logic [19:0] rin;
    logic [17:0] rout;
    logic [3:0]  cc;
    logic [49:0] prior;
    logic signed [33:0] mul_a;
    logic [31:0] mul_b;
    logic signed [66:0] mul_p;
    logic signed [61:0] div_a;
    logic [DIV_W-1:0] div_mag, div_dividend, div_q;
    logic [DVS_W-1:0] div_divisor, div_r;
    logic        div_start, div_done;
    logic        run_last, c_last;

    logic [60:0] enc_dividend;
    logic [10:0] c5_v, c5_rem;
    logic [21:0] c5_prod;
    logic [7:0]  c5_qd;
    logic [26:0] c5_r;

    logic [61:0] pe;
    logic [COUNT_BITS-1:0] t2, tdiff;
    logic [40:0] xmag;
    logic signed [39:0] xcl;
    logic [15:0] q16;
    logic [31:0] q32;
    logic        rnd;
    logic [24:0] qr;
    logic [7:0]  fexp;

    assign rin  = (in_rate_reg == '0) ? 20'(DEFAULT_RATE) : in_rate_reg;
    assign rout = (out_rate_reg == '0) ? 18'(DEFAULT_RATE) : out_rate_reg;
    assign cc   = (chan_reg == '0) ? 4'd1 :
                  (chan_reg > 4'(MAX_CHANNELS)) ? 4'(MAX_CHANNELS) : chan_reg;
    assign prior = (idx_reg == '0) ? '0 : iout_reg - 50'(rout);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_N: begin
                mul_a = 34'({1'b0, idx_reg} + 33'd1);
                mul_b = 32'(rout);
            end
            OP_MUL_I: begin
                mul_a = 34'(idx_reg);
                mul_b = 32'(rout);
            end
            OP_MUL_K: begin
                mul_a = 34'(k_reg);
                mul_b = 32'(rin);
            end
            OP_MUL_A: begin
                mul_a = 34'(prev_reg);
                mul_b = 32'(rout);
            end
            OP_MUL_B: begin
                mul_a = 34'(cur_reg) - 34'(prev_reg);
                mul_b = 32'(num_reg);
            end
            OP_MUL_E: begin
                case (fmt_reg)
                    FMT_U8: begin
                        mul_a = 34'(xc_reg) + 34'(FULL_SCALE);
                        mul_b = 32'd510;
                    end
                    FMT_S16: begin
                        mul_a = 34'(m_reg);
                        mul_b = 32'd65534;
                    end
                    default: begin
                        mul_a = 34'(m_reg);
                        mul_b = 32'hFFFF_FFFE;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    assign div_a   = $signed({acc_reg, 9'b0}) + $signed(62'(rout));
    assign div_mag = div_a[61] ? 61'(-div_a) : div_a[60:0];

    always_comb begin
        div_start    = 1'b1;
        div_dividend = '0;
        div_divisor  = '0;
        case (cmd.op)
            OP_DIV_T: begin
                div_dividend = 61'({prod_reg[51:0], 1'b0}) + 61'(rin);
                div_divisor  = 29'({rin, 1'b0});
            end
            OP_DIV_P: begin
                div_dividend = 61'(prod_reg);
                div_divisor  = 29'(rin);
            end
            OP_DIV_I: begin
                div_dividend = div_mag;
                div_divisor  = 29'({rout, 1'b0});
            end
            default: div_start = 1'b0;
        endcase
    end

    lrpe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_q),
        .remainder (div_r),
        .done      (div_done)
    );

    // divide by five times a power of two: shift, then one byte per cycle
    assign enc_dividend = 61'(prod_reg) +
                          ((fmt_reg == FMT_U8) ? 61'(FS2) : 61'(FULL_SCALE));
    assign c5_v    = {c5_r_reg, c5_y_reg[39:32]};
    assign c5_prod = c5_v * RECIP5;
    assign c5_qd   = c5_prod[20:13];
    assign c5_rem  = c5_v - ({1'b0, c5_qd, 2'b00} + {3'b000, c5_qd});
    assign c5_r    = {c5_r_reg, c5_low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c5_busy_reg <= 1'b0;
            c5_done_reg <= 1'b0;
        end else begin
            c5_done_reg <= 1'b0;
            if (cmd.op inside {OP_DIV_E, OP_DIV_F}) begin
                c5_busy_reg <= 1'b1;
                c5_cnt_reg  <= '0;
                c5_q_reg    <= '0;
                c5_r_reg    <= '0;
                if (cmd.op == OP_DIV_F) begin
                    c5_y_reg   <= {12'b0, sh_reg[51:24]};
                    c5_low_reg <= sh_reg[23:0];
                end else if (fmt_reg == FMT_U8) begin
                    c5_y_reg   <= {5'b0, enc_dividend[60:26]};
                    c5_low_reg <= '0;
                end else begin
                    c5_y_reg   <= {4'b0, enc_dividend[60:25]};
                    c5_low_reg <= '0;
                end
            end else if (c5_busy_reg) begin
                c5_y_reg <= {c5_y_reg[31:0], 8'b0};
                c5_q_reg <= {c5_q_reg[31:0], c5_qd};
                c5_r_reg <= c5_rem[2:0];
                if (c5_cnt_reg == 3'd4) begin
                    c5_busy_reg <= 1'b0;
                    c5_done_reg <= 1'b1;
                end else begin
                    c5_cnt_reg <= c5_cnt_reg + 1'b1;
                end
            end
        end
    end

    assign pe    = 62'(div_q) + 62'd1;
    assign t2    = (target_reg < oidx_reg) ? oidx_reg : target_reg;
    assign tdiff = t2 - oidx_reg;
    assign xmag  = 41'(div_q[39:0]) + 41'(div_r != '0);
    assign xcl   = (x_reg > FS40) ? FS40 : ((x_reg < -FS40) ? -FS40 : x_reg);
    assign q16   = c5_q_reg[15:0];
    assign q32   = c5_q_reg[31:0];
    assign rnd   = ({c5_r, 1'b0} > FULL_SCALE) ||
                   (({c5_r, 1'b0} == FULL_SCALE) && c5_q_reg[0]);
    assign qr    = 25'(c5_q_reg[23:0]) + 25'(rnd);
    assign fexp  = 8'd150 - {2'b00, s_reg} + {7'b0, qr[24]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_rate_reg  <= '0;
            out_rate_reg <= 18'(DEFAULT_RATE);
            fmt_reg      <= FMT_S16;
            chan_reg     <= 4'd1;
            prev_reg     <= '0;
            idx_reg      <= '0;
            oidx_reg     <= '0;
            held_vld_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_IN_RATE:  in_rate_reg  <= cfg_wdata;
                    REG_OUT_RATE: out_rate_reg <= cfg_wdata[17:0];
                    REG_FORMAT:   fmt_reg      <= cfg_wdata[1:0];
                    REG_CHANNELS: chan_reg     <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_ADV: begin
                    if (target_reg != oidx_reg) begin
                        held_vld_reg <= 1'b0;
                        oidx_reg     <= target_reg;
                    end
                end
                OP_HELD_SET: held_vld_reg <= 1'b1;
                OP_FINISH: begin
                    if (last_reg) begin
                        prev_reg     <= '0;
                        idx_reg      <= '0;
                        oidx_reg     <= '0;
                        held_vld_reg <= 1'b0;
                    end else begin
                        prev_reg <= cur_reg;
                        if (idx_reg != COUNT_MAX) begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                cur_reg  <= s_tdata;
                last_reg <= s_tlast;
            end
            OP_MUL_N: prod_reg <= mul_p[59:0];
            OP_SET_T: begin
                if (div_q == '0) begin
                    target_reg <= 32'd1;
                end else if (div_q > 61'(COUNT_MAX)) begin
                    target_reg <= COUNT_MAX;
                end else begin
                    target_reg <= div_q[31:0];
                end
            end
            OP_MUL_I: begin
                prod_reg <= mul_p[59:0];
                iout_reg <= mul_p[49:0];
            end
            OP_MIN_PE: begin
                if (pe < 62'(target_reg)) begin
                    target_reg <= pe[31:0];
                end
            end
            OP_FIX_T: begin
                target_reg <= t2;
                nvals_reg  <= (tdiff > 32'(VALUE_CAP)) ? 4'(VALUE_CAP) : tdiff[3:0];
                j_reg      <= '0;
                c_reg      <= '0;
                k_reg      <= oidx_reg;
            end
            OP_LOAD_HELD: x_reg <= held_reg;
            OP_MUL_K:     kin_reg <= mul_p[51:0];
            OP_CUR_X:     x_reg <= {cur_reg, 8'b0};
            OP_MUL_A: begin
                acc_reg <= mul_p[52:0];
                num_reg <= (kin_reg > 52'(prior)) ? 18'(kin_reg - 52'(prior)) : '0;
            end
            OP_MUL_B:     acc_reg <= acc_reg + mul_p[52:0];
            OP_DIV_I:     dneg_reg <= div_a[61];
            OP_SET_X:     x_reg <= dneg_reg ? 40'(-xmag) : div_q[39:0];
            OP_CLAMP: begin
                xc_reg   <= 28'(xcl);
                fneg_reg <= xcl[39];
                m_reg    <= xcl[39] ? 27'(-xcl) : 27'(xcl);
            end
            OP_MUL_E: prod_reg <= mul_p[59:0];
            OP_SET_CODE: begin
                case (fmt_reg)
                    FMT_U8:  code_reg <= {24'b0, c5_q_reg[7:0]};
                    FMT_S16: code_reg <= {16'b0, fneg_reg ? -q16 : q16};
                    default: code_reg <= fneg_reg ? -q32 : q32;
                endcase
            end
            OP_ZERO_CODE: code_reg <= '0;
            OP_FLT_INIT: begin
                sh_reg <= 52'(m_reg);
                s_reg  <= '0;
            end
            OP_FLT_SHIFT: begin
                sh_reg <= {sh_reg[50:0], 1'b0};
                s_reg  <= s_reg + 1'b1;
            end
            OP_FLT_CODE: begin
                code_reg <= {fneg_reg, fexp, qr[24] ? qr[23:1] : qr[22:0]};
            end
            OP_NEXT_C: c_reg <= c_reg + 1'b1;
            OP_NEXT_J: begin
                j_reg <= j_reg + 1'b1;
                k_reg <= k_reg + 1'b1;
                c_reg <= '0;
            end
            OP_ADV:      k_reg <= target_reg;
            OP_HELD_SET: held_reg <= x_reg;
            default: ;
        endcase
    end

    assign c_last   = ({1'b0, c_reg} == cc - 4'd1);
    assign run_last = c_last && (j_reg + 4'd1 == nvals_reg);

    assign stat.div_done   = div_done | c5_done_reg;
    assign stat.last       = last_reg;
    assign stat.held_vld   = held_vld_reg;
    assign stat.j_done     = (j_reg == nvals_reg);
    assign stat.first_held = (j_reg == '0) && held_vld_reg;
    assign stat.kin_ge     = (kin_reg >= 52'(iout_reg));
    assign stat.kin_le     = (kin_reg <= 52'(iout_reg));
    assign stat.fmt        = fmt_reg;
    assign stat.m_zero     = (m_reg == '0);
    assign stat.sh_low     = (sh_reg < FLT_LIMIT);
    assign stat.c_last     = c_last;

    assign m_tdata = {5'b0, c_reg, code_reg};
    assign m_tlast = run_last;
    assign m_tuser = run_last & last_reg;

endmodule

// ----- rtl/lrpe_ctrl.sv -----
// Controller: sequences the datapath through rate, interpolation and encoding.
module lrpe_ctrl
    import lrpe_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_MUL_N, ST_DIV_T, ST_WAIT_T, ST_SET_T, ST_MUL_I, ST_DIV_P, ST_WAIT_P,
        ST_MIN_PE, ST_FIX_T, ST_LOOP, ST_LD_HELD, ST_MUL_K, ST_ICHK, ST_CUR_X, ST_MUL_A,
        ST_MUL_B, ST_DIV_I, ST_WAIT_I, ST_SET_X, ST_POST_X, ST_CLAMP, ST_SEL_FMT,
        ST_ZERO, ST_MUL_E, ST_DIV_E, ST_WAIT_E, ST_SET_CODE, ST_FLT_INIT, ST_FLT_SHIFT,
        ST_DIV_F, ST_WAIT_F, ST_FLT_CODE, ST_EMIT, ST_ADV, ST_H_CHK, ST_HELD_SET,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   hmode_reg, hmode_next;
    dp_op_t op;

    always_comb begin
        state_next = state_reg;
        hmode_next = hmode_reg;
        op         = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                hmode_next = 1'b0;
                if (s_tvalid) begin
                    op         = OP_LOAD;
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N: begin op = OP_MUL_N; state_next = ST_DIV_T; end
            ST_DIV_T: begin op = OP_DIV_T; state_next = ST_WAIT_T; end
            ST_WAIT_T: if (stat.div_done) state_next = ST_SET_T;
            ST_SET_T: begin op = OP_SET_T; state_next = ST_MUL_I; end
            ST_MUL_I: begin
                op         = OP_MUL_I;
                state_next = stat.last ? ST_FIX_T : ST_DIV_P;
            end
            ST_DIV_P: begin op = OP_DIV_P; state_next = ST_WAIT_P; end
            ST_WAIT_P: if (stat.div_done) state_next = ST_MIN_PE;
            ST_MIN_PE: begin op = OP_MIN_PE; state_next = ST_FIX_T; end
            ST_FIX_T: begin op = OP_FIX_T; state_next = ST_LOOP; end
            ST_LOOP: begin
                if (stat.j_done) begin
                    state_next = ST_ADV;
                end else if (stat.first_held) begin
                    state_next = ST_LD_HELD;
                end else begin
                    state_next = ST_MUL_K;
                end
            end
            ST_LD_HELD: begin op = OP_LOAD_HELD; state_next = ST_CLAMP; end
            ST_MUL_K: begin op = OP_MUL_K; state_next = ST_ICHK; end
            ST_ICHK: begin
                if (hmode_reg && !stat.kin_le) begin
                    state_next = ST_FINISH;
                end else if (stat.kin_ge) begin
                    state_next = ST_CUR_X;
                end else begin
                    state_next = ST_MUL_A;
                end
            end
            ST_CUR_X: begin op = OP_CUR_X; state_next = ST_POST_X; end
            ST_MUL_A: begin op = OP_MUL_A; state_next = ST_MUL_B; end
            ST_MUL_B: begin op = OP_MUL_B; state_next = ST_DIV_I; end
            ST_DIV_I: begin op = OP_DIV_I; state_next = ST_WAIT_I; end
            ST_WAIT_I: if (stat.div_done) state_next = ST_SET_X;
            ST_SET_X: begin op = OP_SET_X; state_next = ST_POST_X; end
            ST_POST_X: state_next = hmode_reg ? ST_HELD_SET : ST_CLAMP;
            ST_CLAMP: begin op = OP_CLAMP; state_next = ST_SEL_FMT; end
            ST_SEL_FMT: begin
                if (stat.fmt != FMT_F32) begin
                    state_next = ST_MUL_E;
                end else if (stat.m_zero) begin
                    state_next = ST_ZERO;
                end else begin
                    state_next = ST_FLT_INIT;
                end
            end
            ST_ZERO: begin op = OP_ZERO_CODE; state_next = ST_EMIT; end
            ST_MUL_E: begin op = OP_MUL_E; state_next = ST_DIV_E; end
            ST_DIV_E: begin op = OP_DIV_E; state_next = ST_WAIT_E; end
            ST_WAIT_E: if (stat.div_done) state_next = ST_SET_CODE;
            ST_SET_CODE: begin op = OP_SET_CODE; state_next = ST_EMIT; end
            ST_FLT_INIT: begin op = OP_FLT_INIT; state_next = ST_FLT_SHIFT; end
            ST_FLT_SHIFT: begin
                if (stat.sh_low) begin
                    op = OP_FLT_SHIFT;
                end else begin
                    state_next = ST_DIV_F;
                end
            end
            ST_DIV_F: begin op = OP_DIV_F; state_next = ST_WAIT_F; end
            ST_WAIT_F: if (stat.div_done) state_next = ST_FLT_CODE;
            ST_FLT_CODE: begin op = OP_FLT_CODE; state_next = ST_EMIT; end
            ST_EMIT: begin
                if (m_tready) begin
                    if (stat.c_last) begin
                        op         = OP_NEXT_J;
                        state_next = ST_LOOP;
                    end else begin
                        op = OP_NEXT_C;
                    end
                end
            end
            ST_ADV: begin op = OP_ADV; state_next = ST_H_CHK; end
            ST_H_CHK: begin
                if (!stat.last && !stat.held_vld) begin
                    hmode_next = 1'b1;
                    state_next = ST_MUL_K;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_HELD_SET: begin op = OP_HELD_SET; state_next = ST_FINISH; end
            ST_FINISH: begin op = OP_FINISH; state_next = ST_IDLE; end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            hmode_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hmode_reg <= hmode_next;
        end
    end

    assign cmd.op   = op;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);

endmodule

// ----- rtl/linear_resample_pcm_encoder.sv -----
// Top level: linear-interpolation resampler with PCM encoder.
//
// Input stream: one voltage sample per word (s_tdata, Q16.16), s_tlast on the
// final sample of a buffer. Output stream: one encoded copy per resampled value
// and channel; m_tlast closes the words caused by one input word, m_tuser marks
// the close of the whole buffer. Rates, format and channel count are written
// through cfg_wr_en/cfg_index/cfg_wdata; the user must write them only while
// the block is idle, which the block itself does not enforce. One input word
// at a time: the rate step comes first, then each resampled value takes
// interpolation (a held value skips it) and encoding, then one output word
// per channel copy; up to eight values per word, and a further interpolation
// may follow to hold the next value. The rate and interpolation stages use
// the 61-step one-bit-per-cycle divider; encoding divides by five a byte per
// cycle.
// Synchronous reset clears buffer state and loads the default configuration;
// no clearing pass follows. When the receiver stalls, the current word holds
// on m_tdata and the block takes no new input until all words are delivered.
module linear_resample_pcm_encoder
    import lrpe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample_volts
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] code, [34:32] channel, [39:35] zero
    output logic        m_tlast,
    output logic [0:0]  m_tuser,   // [0] buffer_end
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    lrpe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lrpe_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
